// File: hdl/linear_probe_hash_table_macros.svh
// Assertion macros for the hash table RTL.
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`ifndef SYNTHESIS
// Check a property while the block is out of reset.
`define LPHT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check a property at every edge, reset included.
`define LPHT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPHT_ASSERT(lbl, clk, rstn, prop, msg)
`define LPHT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: hdl/lpht_pkg.sv
package lpht_pkg;

    // Table geometry; the depth is a power of two so the home slot is a mask.
    localparam int SLOT_W      = 10;
    localparam int TABLE_DEPTH = 1 << SLOT_W;
    localparam int CNT_W       = SLOT_W + 2;
    localparam int KEY_W       = 64;
    localparam int VAL_W       = 16;

    // FNV-1a prime, but the basis is not the standard FNV-1a offset basis. The prime is 2^40 plus a small odd term.
    localparam logic [63:0] FNV_BASIS   = 64'd1469598103934665603;
    localparam logic [63:0] FNV_PRIME   = 64'd1099511628211;
    localparam int          FNV_SHIFT   = 40;
    localparam logic [8:0]  FNV_PRIME_LO = 9'(FNV_PRIME - (64'd1 << FNV_SHIFT));

    // Request codes.
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // One table slot as stored in memory.
    typedef struct packed {
        logic             v;
        logic [KEY_W-1:0] k;
        logic [VAL_W-1:0] val;
    } t_entry;

    // Result of the hash unit.
    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] slot;
    } t_hash_res;

endpackage

// File: hdl/lpht_if.sv
// Request channel.
interface lpht_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 req_type;
    logic [lpht_pkg::KEY_W-1:0] key;
    logic [lpht_pkg::VAL_W-1:0] entry_value;
    modport source (output valid, req_type, key, entry_value, input ready);
    modport sink (input valid, req_type, key, entry_value, output ready);
endinterface

// Response channel.
interface lpht_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic [lpht_pkg::VAL_W-1:0] found_value;
    modport source (output valid, status, found_value, input ready);
    modport sink (input valid, status, found_value, output ready);
endinterface

// File: hdl/linear_probe_hash_table.sv
// Channel  | Dir | Payload
// i_req    | in  | req_type, key, entry_value
// o_rsp    | out | status, found_value
//
// Each request is hashed, then probes slot by slot (a table read, then a check);
// a remove also walks the backward shift, rehashing each entry that it reads.
// The hash unit (one byte per cycle) and the single table memory port set the pace.
// After reset a clearing pass writes all 1024 slots empty; no request
// is taken meanwhile. One request is worked at a time; a new one is taken when
// the sequencer is idle, and a finished response waits in its register.
module linear_probe_hash_table (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lpht_req_if.sink   i_req,
    lpht_rsp_if.source o_rsp
);
`include "linear_probe_hash_table_macros.svh"

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_HASH  = 10'b0000000100,
        S_RD    = 10'b0000001000,
        S_CHK   = 10'b0000010000,
        S_DRD   = 10'b0000100000,
        S_DCHK  = 10'b0001000000,
        S_DHASH = 10'b0010000000,
        S_DCLR  = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    localparam int SW = lpht_pkg::SLOT_W;

    t_state                     r_state, n_state;
    logic [SW-1:0]              r_i, n_i;
    logic [SW-1:0]              r_j, n_j;
    logic [lpht_pkg::CNT_W-1:0] r_n, n_n;
    logic [1:0]                 r_req;
    logic [63:0]                r_key;
    logic [15:0]                r_val;
    logic [63:0]                r_dkey, n_dkey;
    logic [15:0]                r_dval, n_dval;
    logic [1:0]                 r_st, n_st;
    logic [15:0]                r_fv, n_fv;
    logic                       r_out_valid;
    logic [1:0]                 r_out_st;
    logic [15:0]                r_out_fv;

    logic                       w_acc;
    logic [63:0]                w_canon;
    logic                       w_alive;
    logic                       w_hstart;
    logic [63:0]                w_hkey;
    lpht_pkg::t_hash_res        w_hres;
    logic                       w_we;
    logic [SW-1:0]              w_addr;
    lpht_pkg::t_entry           w_wdata;
    lpht_pkg::t_entry           w_rdata;
    logic                       w_keep;
    logic [lpht_pkg::CNT_W-1:0] w_ninc;

    assign w_acc       = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // Clear every byte after the first zero byte.
    always_comb begin
        w_alive = 1'b1;
        w_canon = '0;
        for (int b = 0; b < 8; b++) begin
            if (i_req.key[8*b +: 8] == 8'd0) begin
                w_alive = 1'b0;
            end
            if (w_alive) begin
                w_canon[8*b +: 8] = i_req.key[8*b +: 8];
            end
        end
    end

    // Shared hash unit: request keys and keys read back during the shift.
    assign w_hstart = w_acc || (r_state == S_DCHK && n_state == S_DHASH);
    assign w_hkey   = w_acc ? w_canon : w_rdata.k;

    lpht_fnv u_fnv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hstart),
        .i_key   (w_hkey),
        .o_res   (w_hres)
    );

    lpht_ram #(
        .W     ($bits(lpht_pkg::t_entry)),
        .DEPTH (lpht_pkg::TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    // Does the entry at j stay put: its home lies cyclically in (i, j].
    assign w_keep = (r_i <= r_j) ? (r_i < w_hres.slot && w_hres.slot <= r_j)
                                 : (r_i < w_hres.slot || w_hres.slot <= r_j);
    assign w_ninc = r_n + 1'b1;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_n     = r_n;
        n_dkey  = r_dkey;
        n_dval  = r_dval;
        n_st    = r_st;
        n_fv    = r_fv;
        w_we    = 1'b0;
        w_addr  = r_i;
        w_wdata = '{v: 1'b0, k: r_key, val: r_val};
        unique case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
                n_i  = r_i + 1'b1;
                if (r_i == SW'(lpht_pkg::TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_acc) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                n_i  = w_hres.slot;
                n_n  = '0;
                n_st = lpht_pkg::ST_NOT_FOUND;
                n_fv = '0;
                if (w_hres.done) begin
                    if (r_req == lpht_pkg::REQ_INSERT || r_req == lpht_pkg::REQ_REMOVE ||
                        (r_req == lpht_pkg::REQ_LOOKUP && r_key != 64'd0)) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_req == lpht_pkg::REQ_INSERT) begin
                    if (!w_rdata.v) begin
                        w_we    = 1'b1;
                        w_wdata = '{v: 1'b1, k: r_key, val: r_val};
                        n_st    = lpht_pkg::ST_OK;
                        n_state = S_DONE;
                    end else if (r_n == lpht_pkg::CNT_W'(lpht_pkg::TABLE_DEPTH - 1)) begin
                        n_st    = lpht_pkg::ST_FULL;
                        n_state = S_DONE;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_n     = w_ninc;
                        n_state = S_RD;
                    end
                end else if (!w_rdata.v) begin
                    n_state = S_DONE;
                end else if (w_rdata.k == r_key) begin
                    n_st = lpht_pkg::ST_OK;
                    if (r_req == lpht_pkg::REQ_LOOKUP) begin
                        n_fv    = w_rdata.val;
                        n_state = S_DONE;
                    end else begin
                        // Empty the matched slot and start the backward shift.
                        w_we    = 1'b1;
                        n_j     = r_i + 1'b1;
                        n_n     = '0;
                        n_state = S_DRD;
                    end
                end else if (r_n == lpht_pkg::CNT_W'(lpht_pkg::TABLE_DEPTH - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_n     = w_ninc;
                    n_state = S_RD;
                end
            end
            S_DRD: begin
                w_addr  = r_j;
                n_state = S_DCHK;
            end
            S_DCHK: begin
                w_addr = r_j;
                n_dkey = w_rdata.k;
                n_dval = w_rdata.val;
                n_n    = w_ninc;
                if (!w_rdata.v || r_j == r_i ||
                    w_ninc > lpht_pkg::CNT_W'(lpht_pkg::TABLE_DEPTH)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_DHASH;
                end
            end
            S_DHASH: begin
                if (w_hres.done) begin
                    if (w_keep) begin
                        n_j     = r_j + 1'b1;
                        n_state = S_DRD;
                    end else begin
                        // Move the entry at j back into the hole at i.
                        w_we    = 1'b1;
                        w_wdata = '{v: 1'b1, k: r_dkey, val: r_dval};
                        n_i     = r_j;
                        n_state = S_DCLR;
                    end
                end
            end
            S_DCLR: begin
                w_we    = 1'b1;
                n_j     = r_i + 1'b1;
                n_state = S_DRD;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_i         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            if (r_state == S_DONE && n_state == S_IDLE) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_j    <= n_j;
        r_n    <= n_n;
        r_dkey <= n_dkey;
        r_dval <= n_dval;
        r_st   <= n_st;
        r_fv   <= n_fv;
        if (w_acc) begin
            r_req <= i_req.req_type;
            r_key <= w_canon;
            r_val <= i_req.entry_value;
        end
        if (r_state == S_DONE && n_state == S_IDLE) begin
            r_out_st <= r_st;
            r_out_fv <= r_fv;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_st;
    assign o_rsp.found_value = r_out_fv;

    `LPHT_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> r_state == S_CLEAR, "no clear after reset")
    `LPHT_ASSERT(a_lookup_no_write, i_clk, i_rst_n, (r_state != S_CLEAR && r_req == lpht_pkg::REQ_LOOKUP) |-> !w_we, "lookup wrote the table")
    `LPHT_ASSERT(a_hash_done_state, i_clk, i_rst_n, w_hres.done |-> (r_state == S_HASH || r_state == S_DHASH), "hash result unexpected")
    `LPHT_ASSERT(a_done_loads_out, i_clk, i_rst_n, (r_state == S_DONE && n_state == S_IDLE) |=> r_out_valid, "response lost")
endmodule

// File: hdl/lpht_ram.sv
module lpht_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [W-1:0]             i_wdata,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // Single port, registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/lpht_fnv.sv
module lpht_fnv (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lpht_pkg::KEY_W-1:0] i_key,
    output lpht_pkg::t_hash_res        o_res
);
    logic        r_busy;
    logic        r_done;
    logic [63:0] r_h;
    logic [63:0] r_k;
    logic [63:0] w_x;
    logic [63:0] w_mul;

    // One key byte per cycle: xor, then multiply by the prime as shift plus small product.
    assign w_x   = r_h ^ {56'd0, r_k[7:0]};
    assign w_mul = (w_x << lpht_pkg::FNV_SHIFT) + (w_x * 64'(lpht_pkg::FNV_PRIME_LO));

    // Control: the key is canonical, so the first zero byte ends the walk.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_k[7:0] == 8'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Hash and remaining key bytes.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_h <= lpht_pkg::FNV_BASIS;
            r_k <= i_key;
        end else if (r_busy && r_k[7:0] != 8'd0) begin
            r_h <= w_mul;
            r_k <= r_k >> 8;
        end
    end

    assign o_res.done = r_done;
    assign o_res.slot = r_h[lpht_pkg::SLOT_W-1:0];
endmodule

// File: tb/lpht_table_checker.sv
// Watches both channels of the hash table, keeps its own copy of the table,
// and compares every response with the oldest expected one.
module lpht_table_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    input  logic                       i_req_ready,
    input  logic [1:0]                 i_req_type,
    input  logic [lpht_pkg::KEY_W-1:0] i_key,
    input  logic [lpht_pkg::VAL_W-1:0] i_entry_value,
    input  logic                       i_rsp_valid,
    input  logic                       i_rsp_ready,
    input  logic [1:0]                 i_status,
    input  logic [lpht_pkg::VAL_W-1:0] i_found_value,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_occupied
);

    typedef struct {
        logic [1:0]                 status;
        logic [lpht_pkg::VAL_W-1:0] found_value;
    } t_answer;

    // Shadow copy of the table.
    logic [lpht_pkg::KEY_W-1:0] slot_key [lpht_pkg::TABLE_DEPTH];
    logic [lpht_pkg::VAL_W-1:0] slot_val [lpht_pkg::TABLE_DEPTH];
    bit                         slot_used[lpht_pkg::TABLE_DEPTH];

    t_answer answer_q[$];

    // Clear every byte after the first zero byte.
    function automatic logic [lpht_pkg::KEY_W-1:0] canon_key(logic [lpht_pkg::KEY_W-1:0] k);
        logic [lpht_pkg::KEY_W-1:0] r;
        bit                         ended;
        r = '0;
        ended = 0;
        for (int b = 0; b < 8; b++) begin
            if (k[8*b +: 8] == 8'd0) ended = 1;
            if (!ended) r[8*b +: 8] = k[8*b +: 8];
        end
        return r;
    endfunction

    // FNV-1a style hash with the package constants over the key bytes, masked to the table depth.
    function automatic int home_of(logic [lpht_pkg::KEY_W-1:0] ck);
        logic [63:0] h;
        bit          ended;
        h = lpht_pkg::FNV_BASIS;
        ended = 0;
        for (int b = 0; b < 8; b++) begin
            if (ck[8*b +: 8] == 8'd0) ended = 1;
            if (!ended) begin
                h = h ^ {56'd0, ck[8*b +: 8]};
                h = h * lpht_pkg::FNV_PRIME;
            end
        end
        return int'(h % lpht_pkg::TABLE_DEPTH);
    endfunction

    // Slot of the first live match, or the table depth when absent.
    function automatic int find_slot(logic [lpht_pkg::KEY_W-1:0] ck);
        int  i;
        int  hit;
        bit  searching;
        i = home_of(ck);
        hit = lpht_pkg::TABLE_DEPTH;
        searching = 1;
        for (int n = 0; n < lpht_pkg::TABLE_DEPTH && searching; n++) begin
            if (!slot_used[i]) begin
                searching = 0;
            end else if (slot_key[i] == ck) begin
                hit = i;
                searching = 0;
            end else begin
                i = (i + 1) % lpht_pkg::TABLE_DEPTH;
            end
        end
        return hit;
    endfunction

    // Backward-shift deletion: pull later chain members into the hole.
    function automatic void shift_delete(int hole);
        int i, j, k, n;
        bit moving, searching, keep;
        i = hole;
        n = 0;
        moving = 1;
        while (moving) begin
            j = i;
            slot_used[i] = 0;
            moving = 0;
            searching = 1;
            while (searching) begin
                j = (j + 1) % lpht_pkg::TABLE_DEPTH;
                if (!slot_used[j] || j == i) begin
                    searching = 0;
                end else begin
                    n++;
                    if (n > lpht_pkg::TABLE_DEPTH) begin
                        searching = 0;
                    end else begin
                        k = home_of(slot_key[j]);
                        keep = (i <= j) ? (i < k && k <= j) : (i < k || k <= j);
                        if (!keep) begin
                            searching = 0;
                            moving = 1;
                        end
                    end
                end
            end
            if (moving) begin
                slot_key[i]  = slot_key[j];
                slot_val[i]  = slot_val[j];
                slot_used[i] = 1;
                i = j;
            end
        end
    endfunction

    // Apply one request to the shadow table and return its answer.
    function automatic t_answer serve(logic [1:0] rt, logic [lpht_pkg::KEY_W-1:0] raw,
                                      logic [lpht_pkg::VAL_W-1:0] v);
        t_answer                    a;
        logic [lpht_pkg::KEY_W-1:0] ck;
        int                         i;
        bit                         placing;
        ck = canon_key(raw);
        a.status = lpht_pkg::ST_NOT_FOUND;
        a.found_value = '0;
        if (rt == lpht_pkg::REQ_INSERT) begin
            a.status = lpht_pkg::ST_FULL;
            i = home_of(ck);
            placing = 1;
            for (int n = 0; n < lpht_pkg::TABLE_DEPTH && placing; n++) begin
                if (!slot_used[i]) begin
                    slot_key[i]  = ck;
                    slot_val[i]  = v;
                    slot_used[i] = 1;
                    o_occupied++;
                    a.status = lpht_pkg::ST_OK;
                    placing = 0;
                end else begin
                    i = (i + 1) % lpht_pkg::TABLE_DEPTH;
                end
            end
        end else if (rt == lpht_pkg::REQ_LOOKUP) begin
            if (ck != '0) begin
                i = find_slot(ck);
                if (i < lpht_pkg::TABLE_DEPTH) begin
                    a.status = lpht_pkg::ST_OK;
                    a.found_value = slot_val[i];
                end
            end
        end else if (rt == lpht_pkg::REQ_REMOVE) begin
            i = find_slot(ck);
            if (i < lpht_pkg::TABLE_DEPTH) begin
                shift_delete(i);
                o_occupied--;
                a.status = lpht_pkg::ST_OK;
            end
        end
        return a;
    endfunction

    // Responses are checked before the request of the same edge is predicted.
    always @(posedge i_clk) begin
        t_answer exp_a;
        if (!i_rst_n) begin
            for (int s = 0; s < lpht_pkg::TABLE_DEPTH; s++) slot_used[s] = 0;
            answer_q.delete();
            o_occupied   = 0;
            o_pending    = 0;
            o_fail_count = 0;
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (answer_q.size() == 0) begin
                    $error("response transfer with no request outstanding");
                    o_fail_count++;
                end else begin
                    exp_a = answer_q.pop_front();
                    if (i_status !== exp_a.status) begin
                        $error("status: expected %0d, actual %0d", exp_a.status, i_status);
                        o_fail_count++;
                    end
                    if (i_found_value !== exp_a.found_value) begin
                        $error("found_value: expected %0h, actual %0h",
                               exp_a.found_value, i_found_value);
                        o_fail_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                answer_q.push_back(serve(i_req_type, i_key, i_entry_value));
            o_pending = answer_q.size();
        end
    end

endmodule

// File: tb/tb.sv
module tb;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int         POOL_SIZE  = 40;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   occupied;
    int   tx_idle_pct;
    int   rx_idle_pct;

    logic [lpht_pkg::KEY_W-1:0] key_pool[POOL_SIZE];
    logic [lpht_pkg::KEY_W-1:0] wrap_keys[3];

    lpht_req_if req_ch ();
    lpht_rsp_if rsp_ch ();

    linear_probe_hash_table i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    lpht_table_checker u_table_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (req_ch.valid),
        .i_req_ready   (req_ch.ready),
        .i_req_type    (req_ch.req_type),
        .i_key         (req_ch.key),
        .i_entry_value (req_ch.entry_value),
        .i_rsp_valid   (rsp_ch.valid),
        .i_rsp_ready   (rsp_ch.ready),
        .i_status      (rsp_ch.status),
        .i_found_value (rsp_ch.found_value),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_occupied    (occupied)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run limit; covers the clearing pass and a completely full table.
    initial begin
        #(8 * 8_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    // Response back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Key of the given length with nonzero bytes, zero padded.
    function automatic logic [lpht_pkg::KEY_W-1:0] make_key(int len);
        logic [lpht_pkg::KEY_W-1:0] k;
        k = '0;
        for (int b = 0; b < len; b++) k[8*b +: 8] = 8'($urandom_range(1, 255));
        return k;
    endfunction

    // Same key after its terminator gets random trailing bytes half the time.
    function automatic logic [lpht_pkg::KEY_W-1:0] add_tail(logic [lpht_pkg::KEY_W-1:0] k);
        logic [lpht_pkg::KEY_W-1:0] r;
        bit                         ended;
        r = k;
        ended = 0;
        if ($urandom_range(0, 1) == 1) begin
            for (int b = 0; b < 8; b++) begin
                if (ended) r[8*b +: 8] = 8'($urandom);
                if (k[8*b +: 8] == 8'd0) ended = 1;
            end
        end
        return r;
    endfunction

    // One request transfer; valid stays high unless a gap is taken.
    task automatic send(logic [1:0] rt, logic [lpht_pkg::KEY_W-1:0] k,
                        logic [lpht_pkg::VAL_W-1:0] v);
        bit taken;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= rt;
        req_ch.key         <= k;
        req_ch.entry_value <= v;
        do begin
            @(negedge i_clk);
            taken = req_ch.ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // Hold the request side until every response is back.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // One random request, mostly on pooled keys so that hits are common.
    task automatic random_request();
        int                         pick;
        logic [lpht_pkg::KEY_W-1:0] k;
        pick = $urandom_range(0, 99);
        k = add_tail(key_pool[$urandom_range(0, POOL_SIZE - 1)]);
        if (pick < 40)
            send(lpht_pkg::REQ_INSERT, k, 16'($urandom));
        else if (pick < 70)
            send(lpht_pkg::REQ_LOOKUP,
                 ($urandom_range(0, 6) == 0) ? {$urandom, $urandom} : k,
                 16'($urandom));
        else if (pick < 92)
            send(lpht_pkg::REQ_REMOVE, k, 16'($urandom));
        else if (pick < 96)
            send(2'($urandom_range(0, 2)), {$urandom, $urandom}, 16'($urandom));
        else
            send(REQ_UNUSED, k, 16'($urandom));
    endtask

    initial begin
        logic [lpht_pkg::KEY_W-1:0] k;
        int                         need;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        i_rst_n = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = lpht_pkg::REQ_INSERT;
        req_ch.key         = '0;
        req_ch.entry_value = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < POOL_SIZE; p++) key_pool[p] = make_key($urandom_range(0, 8));
        // Three distinct keys whose home is the last slot, to force wrap-around.
        for (int w = 0; w < 3; w++) begin
            do k = make_key($urandom_range(1, 8));
            while (u_table_chk.home_of(k) != lpht_pkg::TABLE_DEPTH - 1 ||
                   (w > 0 && k == wrap_keys[0]) || (w > 1 && k == wrap_keys[1]));
            wrap_keys[w] = k;
        end

        // Directed part: empty key, tails after a zero byte, all-ones key,
        // absent keys, the unused request type, and chains that wrap.
        send(lpht_pkg::REQ_INSERT, 64'd0, 16'hFFFF);
        send(lpht_pkg::REQ_LOOKUP, 64'd0, 16'd0);
        send(lpht_pkg::REQ_REMOVE, 64'hFFFF_FFFF_FF00_0000, 16'd0);
        send(lpht_pkg::REQ_INSERT, 64'hA5C3_0000_0000_4241, 16'h0000);
        send(lpht_pkg::REQ_LOOKUP, 64'h0000_005A_0000_4241, 16'h1234);
        send(lpht_pkg::REQ_INSERT, '1, 16'hFFFF);
        send(lpht_pkg::REQ_LOOKUP, '1, 16'd0);
        send(lpht_pkg::REQ_REMOVE, '1, 16'd0);
        send(lpht_pkg::REQ_LOOKUP, '1, 16'd0);
        send(lpht_pkg::REQ_REMOVE, '1, 16'd0);
        send(REQ_UNUSED, 64'h4241, 16'hFFFF);
        for (int w = 0; w < 3; w++)
            send(lpht_pkg::REQ_INSERT, wrap_keys[w], 16'(w + 16'hBEE0));
        for (int w = 0; w < 3; w++) send(lpht_pkg::REQ_LOOKUP, wrap_keys[w], 16'd0);
        send(lpht_pkg::REQ_REMOVE, wrap_keys[0], 16'd0);
        send(lpht_pkg::REQ_LOOKUP, wrap_keys[1], 16'd0);
        send(lpht_pkg::REQ_LOOKUP, wrap_keys[2], 16'd0);
        send(lpht_pkg::REQ_REMOVE, 64'h4241, 16'd0);
        send(lpht_pkg::REQ_LOOKUP, 64'h4241, 16'd0);
        drain();

        // Random part in three idling phases.
        tx_idle_pct = 28;
        rx_idle_pct = 60;
        for (int n = 0; n < 180; n++) random_request();
        drain();
        tx_idle_pct = 60;
        rx_idle_pct = 28;
        for (int n = 0; n < 180; n++) random_request();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int n = 0; n < 190; n++) random_request();
        drain();

        // Fill the table completely, then work against a full table.
        need = lpht_pkg::TABLE_DEPTH - occupied;
        for (int n = 0; n < need; n++)
            send(lpht_pkg::REQ_INSERT, {$urandom, $urandom}, 16'($urandom));
        k = key_pool[0];
        send(lpht_pkg::REQ_INSERT, k, 16'h5555);
        send(lpht_pkg::REQ_INSERT, 64'd0, 16'hAAAA);
        send(lpht_pkg::REQ_LOOKUP, 64'hFEFE_FEFE_FEFE_FEFE, 16'd0);
        send(lpht_pkg::REQ_REMOVE, 64'hFEFE_FEFE_FEFE_FEFE, 16'd0);
        send(lpht_pkg::REQ_LOOKUP, key_pool[1], 16'd0);
        for (int r = 0; r < 3; r++) begin
            send(lpht_pkg::REQ_REMOVE, key_pool[r], 16'd0);
            send(lpht_pkg::REQ_LOOKUP, key_pool[r], 16'd0);
        end
        send(lpht_pkg::REQ_INSERT, k, 16'h7777);
        send(lpht_pkg::REQ_LOOKUP, k, 16'd0);
        drain();

        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
